// ===== rtl/cbnc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbnc_pkg
// Shared constants, types and the hit-count bucketing function for the
// coverage bitmap novelty check.
// ----------------------------------------------------------------------------
`default_nettype none

package cbnc_pkg;

  // map geometry (MAP_BYTES is a power of two)
  localparam int unsigned MAP_BYTES   = 65536;
  localparam int unsigned MAP_WORDS   = MAP_BYTES / 8;
  localparam int unsigned MAP_AW      = $clog2(MAP_WORDS);
  localparam int unsigned STORE_WORDS = 2 * MAP_WORDS;
  localparam int unsigned STORE_AW    = MAP_AW + 1;

  // payload widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned INDEX_W = 13;
  localparam int unsigned IDX_W   = (MAP_AW < INDEX_W) ? MAP_AW : INDEX_W;
  localparam int unsigned NOV_W   = 2;

  localparam logic [7:0] BYTE_PRISTINE = 8'hff;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STORE_AW-1:0] slot_t;

  // novelty codes
  typedef enum logic [NOV_W-1:0] {
    NOV_NONE   = 2'd0,
    NOV_COUNTS = 2'd1,
    NOV_EDGES  = 2'd2
  } novelty_e;

  // map selector
  typedef enum logic {
    MODE_NORMAL = 1'b0,
    MODE_CRASH  = 1'b1
  } mode_e;

  // hit count to bucket bit
  function automatic logic [7:0] bucket_byte(input logic [7:0] c);
    logic [7:0] r;
    if (c <= 8'd2)        r = c;
    else if (c == 8'd3)   r = 8'd4;
    else if (c < 8'd8)    r = 8'd8;
    else if (c < 8'd16)   r = 8'd16;
    else if (c < 8'd32)   r = 8'd32;
    else if (c < 8'd128)  r = 8'd64;
    else                  r = 8'd128;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/coverage_bitmap_novelty_check.sv =====
// Flow: an accepted input beat waits in stage 1 for its virgin word, then is
// registered into the output register. Throughput: one beat per cycle unless
// the output stalls, set by one virgin map read-modify-write per beat on the
// dual-port RAM, with write-to-read forwarding.
// Reset: after rst_ni releases, a clearing pass writes all ones to the
// 16384 virgin words, one per cycle; in_ready_o stays low until it ends.
// ----------------------------------------------------------------------------
// coverage_bitmap_novelty_check
// Hit-count bucketing and novelty check of trace words against the normal
// and crash virgin maps held in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_bitmap_novelty_check (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [cbnc_pkg::INDEX_W-1:0]    word_index_i,
  input  wire logic [cbnc_pkg::WORD_W-1:0]     trace_word_i,
  input  wire logic                            last_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [cbnc_pkg::WORD_W-1:0]     classified_word_o,
  output logic      [cbnc_pkg::NOV_W-1:0]      novelty_o,
  output logic                                 pass_done_o
);
  import cbnc_pkg::*;

  // clearing pass
  logic  clearing_q;
  slot_t clr_addr_q;

  // stage 1: item waiting for its virgin word
  logic  s1_valid_q;
  word_t s1_cur_q;
  slot_t s1_slot_q;
  logic  s1_last_q;

  // last write, for forwarding
  logic  fwd_valid_q;
  slot_t fwd_slot_q;
  word_t fwd_data_q;

  // running novelty and output register
  logic [NOV_W-1:0] nov_q;
  logic             out_valid_q;
  word_t            out_word_q;
  logic [NOV_W-1:0] out_nov_q;
  logic             out_last_q;

  word_t            cur_in;
  slot_t            slot_in;
  word_t            rdata;
  word_t            vir;
  word_t            vir_new;
  logic             hit;
  logic             pristine;
  logic [NOV_W-1:0] nov_next;
  logic             s1_adv;
  logic             in_acc;
  logic             ram_we;
  slot_t            ram_waddr;
  word_t            ram_wdata;

  // input side
  cbnc_classify u_classify (
    .mode_i (mode_i),
    .word_i (trace_word_i),
    .word_o (cur_in)
  );

  assign slot_in    = {mode_i, MAP_AW'(word_index_i[IDX_W-1:0])};
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // virgin word with forwarding from the previous write
  assign vir = (fwd_valid_q && (fwd_slot_q == s1_slot_q)) ? fwd_data_q : rdata;

  // overlap and pristine byte check
  always_comb begin
    pristine = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if ((s1_cur_q[8*k +: 8] != 8'd0) && (vir[8*k +: 8] == BYTE_PRISTINE)) begin
        pristine = 1'b1;
      end
    end
  end

  assign hit     = |(s1_cur_q & vir);
  assign vir_new = vir & ~s1_cur_q;

  always_comb begin
    nov_next = nov_q;
    if (hit && (nov_q != NOV_EDGES)) begin
      nov_next = pristine ? NOV_EDGES : NOV_COUNTS;
    end
  end

  // write port: clearing pass or write-back
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '1;
    end else begin
      ram_we    = s1_adv;
      ram_waddr = s1_slot_q;
      ram_wdata = vir_new;
    end
  end

  cbnc_virgin_ram #(
    .DataW (WORD_W),
    .Depth (STORE_WORDS),
    .AddrW (STORE_AW)
  ) u_virgin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (slot_in),
    .rdata_o (rdata)
  );

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + slot_t'(1);
      if (clr_addr_q == slot_t'(STORE_WORDS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      nov_q       <= NOV_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        fwd_valid_q <= 1'b1;
        nov_q       <= s1_last_q ? NOV_NONE : nov_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cur_q  <= cur_in;
      s1_slot_q <= slot_in;
      s1_last_q <= last_word_i;
    end
    if (s1_adv) begin
      fwd_slot_q <= s1_slot_q;
      fwd_data_q <= vir_new;
      out_word_q <= s1_cur_q;
      out_nov_q  <= nov_next;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign classified_word_o = out_word_q;
  assign novelty_o         = out_nov_q;
  assign pass_done_o       = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/cbnc_virgin_ram.sv =====
// ----------------------------------------------------------------------------
// cbnc_virgin_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbnc_virgin_ram #(
  parameter int unsigned DataW = 64,
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cbnc_classify.sv =====
// ----------------------------------------------------------------------------
// cbnc_classify
// Buckets the eight hit-count bytes of a trace word for the normal map;
// crash-map words pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module cbnc_classify (
  input  wire logic            mode_i,
  input  wire cbnc_pkg::word_t word_i,
  output cbnc_pkg::word_t      word_o
);
  import cbnc_pkg::*;

  word_t bucketed;

  // per-byte lookup
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bucketed[8*k +: 8] = bucket_byte(word_i[8*k +: 8]);
    end
  end

  assign word_o = (mode_i == MODE_CRASH) ? word_i : bucketed;

endmodule

`default_nettype wire
